FILE: hw/rtl/ers_pkg.sv
package ers_pkg;

  localparam int FLOORS_DEF    = 64;
  localparam int LOAD_BITS_DEF = 16;
  localparam int FLOOR_BITS    = 6;
  localparam int AMOUNT_BITS   = 16;
  localparam int LIMIT_BITS    = 16;
  localparam int MASK_BITS     = 64;
  localparam int CFG_IDX_BITS  = 2;

  typedef enum logic [2:0] {
    ACT_PRESS     = 3'd0,
    ACT_STEP      = 3'd1,
    ACT_EMERGENCY = 3'd2,
    ACT_CLEAR     = 3'd3,
    ACT_ENTER     = 3'd4,
    ACT_LEAVE     = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    DIR_IDLE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_LOWEST_FLOOR  = 2'd0,
    REG_HIGHEST_FLOOR = 2'd1,
    REG_SECURED_MASK  = 2'd2,
    REG_LOAD_LIMIT    = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    action_t                action;
    logic [FLOOR_BITS-1:0]  floor;
    logic [AMOUNT_BITS-1:0] amount;
  } item_t;

  typedef struct packed {
    logic                   ok;
    logic [FLOOR_BITS-1:0]  car_floor;
    logic [1:0]             direction_out;
    logic                   door_is_open;
    logic                   emergency_out;
    logic [AMOUNT_BITS-1:0] load_out;
  } result_t;

  typedef struct packed {
    cfg_reg_t             index;
    logic [MASK_BITS-1:0] data;
  } cfg_word_t;

  // write strobe plus word, handed from the top level to the core
  typedef struct packed {
    logic      we;
    cfg_word_t word;
  } cfg_wr_t;

endpackage

FILE: hw/rtl/ers_if.sv
interface ers_item_if;
  import ers_pkg::*;
  logic  valid;
  logic  ready;
  item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface ers_result_if;
  import ers_pkg::*;
  logic    valid;
  logic    ready;
  result_t result;
  modport source (output valid, output result, input ready);
  modport sink (input valid, input result, output ready);
endinterface

interface ers_cfg_if;
  import ers_pkg::*;
  logic      valid;
  logic      ready;
  cfg_word_t word;
  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

FILE: hw/rtl/ers_core.sv
module ers_core
  import ers_pkg::*;
#(
  parameter int FLOORS    = FLOORS_DEF,
  parameter int LOAD_BITS = LOAD_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    advance,
  input  item_t   item,
  input  cfg_wr_t cfg_wr,
  output result_t result
);

  localparam int SUM_BITS = ((LOAD_BITS > AMOUNT_BITS) ? LOAD_BITS : AMOUNT_BITS) + 1;

  // configuration
  logic [FLOOR_BITS-1:0] lowest_floor;
  logic [FLOOR_BITS-1:0] highest_floor;
  logic [FLOORS-1:0]     secured_mask;
  logic [LIMIT_BITS-1:0] load_limit;

  // car state
  logic [FLOORS-1:0]     up_pending, up_pending_next;
  logic [FLOORS-1:0]     down_pending, down_pending_next;
  logic [FLOOR_BITS-1:0] position, position_next;
  dir_t                  direction, direction_next;
  logic                  door, door_next;
  logic                  emergency_latch, emergency_latch_next;
  logic [LOAD_BITS-1:0]  car_load, car_load_next;
  logic                  ok;

  logic [FLOOR_BITS-1:0] up_head, down_head;
  logic [FLOORS-1:0]     press_bit, up_head_bit, down_head_bit;
  logic                  press_ok;
  logic signed [FLOOR_BITS+1:0] dist_up, dist_down;
  dir_t                  dir_pick;
  logic [SUM_BITS-1:0]   load_sum, load_max;

  // nearest up request is the lowest bit, nearest down request the highest
  always_comb begin
    up_head = '0;
    for (int i = FLOORS - 1; i >= 0; i--) begin
      if (up_pending[i]) up_head = FLOOR_BITS'(i);
    end
  end

  always_comb begin
    down_head = '0;
    for (int i = 0; i < FLOORS; i++) begin
      if (down_pending[i]) down_head = FLOOR_BITS'(i);
    end
  end

  assign press_bit     = FLOORS'(1) << item.floor;
  assign up_head_bit   = FLOORS'(1) << up_head;
  assign down_head_bit = FLOORS'(1) << down_head;

  assign press_ok = ({1'b0, item.floor} < (FLOOR_BITS + 1)'(FLOORS))
                  && (item.floor >= lowest_floor) && (item.floor <= highest_floor)
                  && ((secured_mask & press_bit) == '0)
                  && (((up_pending | down_pending) & press_bit) == '0)
                  && (item.floor != position);

  assign dist_up   = $signed({2'b00, up_head}) - $signed({2'b00, position});
  assign dist_down = $signed({2'b00, position}) - $signed({2'b00, down_head});

  assign load_sum = SUM_BITS'(car_load) + SUM_BITS'(item.amount);
  assign load_max = SUM_BITS'({LOAD_BITS{1'b1}});

  always_comb begin
    up_pending_next      = up_pending;
    down_pending_next    = down_pending;
    position_next        = position;
    direction_next       = direction;
    door_next            = door;
    emergency_latch_next = emergency_latch;
    car_load_next        = car_load;
    ok                   = 1'b1;
    dir_pick             = direction;

    unique case (item.action)
      ACT_PRESS: begin
        ok = press_ok;
        if (press_ok) begin
          if (item.floor > position) up_pending_next = up_pending | press_bit;
          else down_pending_next = down_pending | press_bit;
        end
      end
      ACT_STEP: begin
        priority if (emergency_latch) begin
          direction_next = DIR_IDLE;
          door_next      = 1'b1;
          ok             = 1'b0;
        end else if (SUM_BITS'(car_load) > SUM_BITS'(load_limit)) begin
          door_next = 1'b1;
          ok        = 1'b0;
        end else if (up_pending == '0 && down_pending == '0) begin
          direction_next = DIR_IDLE;
          ok             = 1'b0;
        end else begin
          door_next = 1'b0;
          if (direction != DIR_UP && direction != DIR_DOWN) begin
            if (up_pending != '0 && down_pending != '0) begin
              dir_pick = (dist_up > dist_down) ? DIR_DOWN : DIR_UP;
            end else begin
              dir_pick = (up_pending != '0) ? DIR_UP : DIR_DOWN;
            end
          end
          direction_next = dir_pick;
          if (dir_pick == DIR_UP) begin
            if (up_pending != '0) begin
              position_next   = up_head;
              door_next       = 1'b1;
              up_pending_next = up_pending & ~up_head_bit;
              if ((up_pending & ~up_head_bit) == '0) direction_next = DIR_IDLE;
            end
          end else begin
            if (down_pending != '0) begin
              position_next     = down_head;
              door_next         = 1'b1;
              down_pending_next = down_pending & ~down_head_bit;
              if ((down_pending & ~down_head_bit) == '0) direction_next = DIR_IDLE;
            end
          end
        end
      end
      ACT_EMERGENCY: emergency_latch_next = 1'b1;
      ACT_CLEAR:     emergency_latch_next = 1'b0;
      ACT_ENTER: begin
        car_load_next = (load_sum > load_max) ? {LOAD_BITS{1'b1}} : LOAD_BITS'(load_sum);
      end
      ACT_LEAVE: begin
        car_load_next = (SUM_BITS'(item.amount) >= SUM_BITS'(car_load)) ? '0
                      : car_load - LOAD_BITS'(item.amount);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lowest_floor    <= '0;
      highest_floor   <= '1;
      secured_mask    <= '0;
      load_limit      <= '1;
      up_pending      <= '0;
      down_pending    <= '0;
      position        <= '0;
      direction       <= DIR_IDLE;
      door            <= 1'b0;
      emergency_latch <= 1'b0;
      car_load        <= '0;
    end else if (cfg_wr.we) begin
      unique case (cfg_wr.word.index)
        REG_LOWEST_FLOOR: begin
          lowest_floor <= cfg_wr.word.data[FLOOR_BITS-1:0];
          position     <= cfg_wr.word.data[FLOOR_BITS-1:0];
        end
        REG_HIGHEST_FLOOR: highest_floor <= cfg_wr.word.data[FLOOR_BITS-1:0];
        REG_SECURED_MASK:  secured_mask  <= cfg_wr.word.data[FLOORS-1:0];
        REG_LOAD_LIMIT:    load_limit    <= cfg_wr.word.data[LIMIT_BITS-1:0];
      endcase
    end else if (advance) begin
      up_pending      <= up_pending_next;
      down_pending    <= down_pending_next;
      position        <= position_next;
      direction       <= direction_next;
      door            <= door_next;
      emergency_latch <= emergency_latch_next;
      car_load        <= car_load_next;
    end
  end

  assign result.ok            = ok;
  assign result.car_floor     = position_next;
  assign result.direction_out = direction_next;
  assign result.door_is_open  = door_next;
  assign result.emergency_out = emergency_latch_next;
  assign result.load_out      = AMOUNT_BITS'(car_load_next);

endmodule

FILE: hw/rtl/elevator_request_scheduler.sv
// Single-car elevator scheduler with collective control. Each request word
// (press, step, emergency, clear, enter, leave) gives exactly one response word
// holding the press/step verdict and the car state after the word. A word is
// captured in an input register, evaluated against the car state (priority
// encoders over the up and down request bitmaps) and loaded into the response
// register, so it sustains one word per cycle while the response is taken;
// a stalled response holds the input register, which takes a new word again
// as soon as the response leaves. Configuration writes are always ready and must
// only be issued while no word is in flight; writing the lowest floor also moves
// the car there.
module elevator_request_scheduler
  import ers_pkg::*;
#(
  parameter int FLOORS    = FLOORS_DEF,
  parameter int LOAD_BITS = LOAD_BITS_DEF
) (
  input logic           clk,
  input logic           rst,
  ers_item_if.sink      req,
  ers_result_if.source  rsp,
  ers_cfg_if.sink       cfg
);

  logic    held_valid;
  item_t   held_item;
  logic    rsp_valid;
  result_t rsp_result;
  logic    advance;
  result_t core_result;
  cfg_wr_t cfg_wr;

  assign advance   = held_valid && (!rsp_valid || rsp.ready);
  assign req.ready = !held_valid || advance;
  assign cfg.ready = 1'b1;

  assign cfg_wr.we   = cfg.valid;
  assign cfg_wr.word = cfg.word;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) held_item <= req.item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) rsp_result <= core_result;
  end

  assign rsp.valid  = rsp_valid;
  assign rsp.result = rsp_result;

  ers_core #(
    .FLOORS    (FLOORS),
    .LOAD_BITS (LOAD_BITS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (held_item),
    .cfg_wr  (cfg_wr),
    .result  (core_result)
  );

endmodule

FILE: dv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ers_pkg::*;

  localparam int            RUN_LIMIT  = 400000;
  localparam action_t       ACT_SPARE6 = action_t'(3'd6);
  localparam action_t       ACT_SPARE7 = action_t'(3'd7);
  localparam logic [3:0]    ALL_REGS   = 4'hF;
  localparam logic [3:0]    SEL_HIGH   = 4'(1 << REG_HIGHEST_FLOOR);

  logic clk;
  logic rst;

  ers_item_if   req ();
  ers_result_if rsp ();
  ers_cfg_if    cfg ();

  elevator_request_scheduler uut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // car model: registers and state
  logic [5:0]  floor_lo;
  logic [5:0]  floor_hi;
  logic [63:0] locked_floors;
  logic [15:0] weight_cap;
  logic [63:0] up_calls;
  logic [63:0] down_calls;
  logic [5:0]  car_pos;
  dir_t        car_dir;
  logic        car_door;
  logic        alarm_on;
  logic [15:0] car_load;

  result_t due_status[$];

  int  errors;
  int  words_sent;
  int  results_seen;
  int  presses_taken;
  int  steps_served;
  int  regs_written;
  int  cycles;
  int  gap_odds;
  int  stall_odds;
  bit  calm;

  function automatic int unsigned lowest_call(input logic [63:0] v);
    for (int i = 0; i < 64; i++)
      if (v[i]) return i;
    return 0;
  endfunction

  function automatic int unsigned highest_call(input logic [63:0] v);
    for (int i = 63; i >= 0; i--)
      if (v[i]) return i;
    return 0;
  endfunction

  function automatic logic take_call(input logic [5:0] f);
    logic [63:0] bit_f;
    bit_f = 64'd1 << f;
    if (f < floor_lo || f > floor_hi) return 1'b0;
    if ((locked_floors & bit_f) != 0) return 1'b0;
    if (((up_calls | down_calls) & bit_f) != 0) return 1'b0;
    if (f == car_pos) return 1'b0;
    if (f > car_pos) up_calls |= bit_f;
    else down_calls |= bit_f;
    return 1'b1;
  endfunction

  function automatic logic run_step();
    int du;
    int dd;
    int unsigned f;
    if (alarm_on) begin
      car_dir  = DIR_IDLE;
      car_door = 1'b1;
      return 1'b0;
    end
    if (car_load > weight_cap) begin
      car_door = 1'b1;
      return 1'b0;
    end
    if (up_calls == 0 && down_calls == 0) begin
      car_dir = DIR_IDLE;
      return 1'b0;
    end
    car_door = 1'b0;
    if (car_dir != DIR_UP && car_dir != DIR_DOWN) begin
      if (up_calls != 0 && down_calls != 0) begin
        du = int'(lowest_call(up_calls)) - int'(car_pos);
        dd = int'(car_pos) - int'(highest_call(down_calls));
        // a tie goes up
        car_dir = (du > dd) ? DIR_DOWN : DIR_UP;
      end else begin
        car_dir = (up_calls != 0) ? DIR_UP : DIR_DOWN;
      end
    end
    if (car_dir == DIR_UP) begin
      if (up_calls != 0) begin
        f = lowest_call(up_calls);
        car_pos = f[5:0];
        car_door = 1'b1;
        up_calls[f] = 1'b0;
        if (up_calls == 0) car_dir = DIR_IDLE;
      end
    end else begin
      if (down_calls != 0) begin
        f = highest_call(down_calls);
        car_pos = f[5:0];
        car_door = 1'b1;
        down_calls[f] = 1'b0;
        if (down_calls == 0) car_dir = DIR_IDLE;
      end
    end
    return 1'b1;
  endfunction

  function automatic result_t next_status(input item_t it);
    result_t     r;
    logic        ok;
    logic [16:0] sum;
    ok = 1'b1;
    case (it.action)
      ACT_PRESS: begin
        ok = take_call(it.floor);
        if (ok) presses_taken++;
      end
      ACT_STEP: begin
        ok = run_step();
        if (ok) steps_served++;
      end
      ACT_EMERGENCY: alarm_on = 1'b1;
      ACT_CLEAR:     alarm_on = 1'b0;
      ACT_ENTER: begin
        sum = {1'b0, car_load} + {1'b0, it.amount};
        car_load = sum[16] ? 16'hFFFF : sum[15:0];
      end
      ACT_LEAVE: car_load = (it.amount >= car_load) ? 16'd0 : car_load - it.amount;
      default: ;
    endcase
    r.ok            = ok;
    r.car_floor     = car_pos;
    r.direction_out = car_dir;
    r.door_is_open  = car_door;
    r.emergency_out = alarm_on;
    r.load_out      = car_load;
    return r;
  endfunction

  task automatic send_word(input action_t act, input logic [5:0] f, input logic [15:0] amt);
    item_t it;
    it.action = act;
    it.floor  = f;
    it.amount = amt;
    if (!calm && $urandom_range(0, 99) < gap_odds) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.item  <= it;
    do @(posedge clk); while (!req.ready);
    due_status.push_back(next_status(it));
    words_sent++;
  endtask

  // stop sending and wait for every outstanding response word
  task automatic settle();
    req.valid <= 1'b0;
    while (due_status.size() != 0) @(posedge clk);
  endtask

  task automatic set_regs(input logic [3:0] sel, input logic [5:0] lo, input logic [5:0] hi,
                          input logic [63:0] mask, input logic [15:0] cap);
    logic [63:0] wdata;
    cfg_reg_t    idx;
    for (int i = 0; i < 4; i++) begin
      idx = cfg_reg_t'(i);
      if (sel[i]) begin
        case (idx)
          REG_LOWEST_FLOOR:  wdata = 64'(lo);
          REG_HIGHEST_FLOOR: wdata = 64'(hi);
          REG_SECURED_MASK:  wdata = mask;
          default:           wdata = 64'(cap);
        endcase
        cfg.valid <= 1'b1;
        cfg.word  <= '{index: idx, data: wdata};
        do @(posedge clk); while (!cfg.ready);
        case (idx)
          REG_LOWEST_FLOOR: begin
            floor_lo = lo;
            car_pos  = lo;
          end
          REG_HIGHEST_FLOOR: floor_hi = hi;
          REG_SECURED_MASK:  locked_floors = mask;
          default:           weight_cap = cap;
        endcase
      end
    end
    cfg.valid <= 1'b0;
    regs_written++;
  endtask

  task automatic test_press_rules();
    settle();
    set_regs(ALL_REGS, 6'd5, 6'd60, 64'h8000_0000_4000_0000, 16'd1000);
    send_word(ACT_PRESS, 6'd0, 16'd0);
    send_word(ACT_PRESS, 6'd61, 16'hFFFF);
    send_word(ACT_PRESS, 6'd30, 16'd0);
    send_word(ACT_PRESS, 6'd5, 16'd0);
    send_word(ACT_PRESS, 6'd20, 16'd0);
    send_word(ACT_PRESS, 6'd20, 16'd0);
    send_word(ACT_PRESS, 6'd10, 16'd0);
    send_word(ACT_STEP, 6'd0, 16'd0);
    send_word(ACT_STEP, 6'd63, 16'd0);
    send_word(ACT_STEP, 6'd0, 16'd0);
  endtask

  task automatic test_load_and_alarm();
    send_word(ACT_ENTER, 6'd0, 16'd40000);
    send_word(ACT_ENTER, 6'd0, 16'd40000);
    send_word(ACT_STEP, 6'd0, 16'd0);
    send_word(ACT_LEAVE, 6'd0, 16'd65534);
    send_word(ACT_LEAVE, 6'd0, 16'hFFFF);
    send_word(ACT_EMERGENCY, 6'd0, 16'd0);
    send_word(ACT_EMERGENCY, 6'd0, 16'd0);
    send_word(ACT_STEP, 6'd0, 16'd0);
    send_word(ACT_CLEAR, 6'd0, 16'd0);
    send_word(ACT_SPARE6, 6'd63, 16'hFFFF);
    send_word(ACT_SPARE7, 6'd0, 16'd0);
  endtask

  task automatic test_range_edges();
    settle();
    set_regs(ALL_REGS, 6'd10, 6'd63, 64'd0, 16'hFFFF);
    send_word(ACT_PRESS, 6'd12, 16'd0);
    send_word(ACT_STEP, 6'd0, 16'd0);
    // equal distance both ways from floor 12
    send_word(ACT_PRESS, 6'd14, 16'd0);
    send_word(ACT_PRESS, 6'd10, 16'd0);
    send_word(ACT_PRESS, 6'd40, 16'd0);
    send_word(ACT_STEP, 6'd0, 16'd0);
    // floor 40 is still pending once the top drops below it
    settle();
    set_regs(SEL_HIGH, 6'd0, 6'd30, 64'd0, 16'd0);
    send_word(ACT_STEP, 6'd0, 16'd0);
    settle();
    set_regs(ALL_REGS, 6'd50, 6'd10, 64'd0, 16'hFFFF);
    send_word(ACT_PRESS, 6'd30, 16'd0);
  endtask

  task automatic test_random_traffic(input int total);
    int          per_phase;
    int          roll;
    logic [5:0]  lo;
    logic [5:0]  hi;
    logic [63:0] mask;
    logic [15:0] cap;
    logic [5:0]  fl;
    logic [15:0] amt;
    per_phase = total / 6;
    for (int ph = 0; ph < 6; ph++) begin
      settle();
      lo   = 6'($urandom_range(0, 62));
      hi   = 6'($urandom_range(lo + 1, 63));
      mask = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      cap  = 16'($urandom);
      case (ph)
        0: begin
          lo = 6'd0; hi = 6'd63; mask = 64'd0; cap = 16'hFFFF;
        end
        1: begin
          lo = 6'd0; hi = 6'd63; cap = 16'd0;
        end
        3: begin
          hi   = 6'($urandom_range(0, 63));
          mask = {$urandom, $urandom};
        end
        default: ;
      endcase
      gap_odds   = (ph == 2) ? 0 : 15;
      stall_odds = (ph == 2) ? 0 : 12;
      calm       = (ph == 5);
      set_regs(ALL_REGS, lo, hi, mask, cap);
      for (int n = 0; n < per_phase; n++) begin
        roll = $urandom_range(0, 99);
        if (floor_lo <= floor_hi && $urandom_range(0, 99) < 85)
          fl = 6'($urandom_range(floor_lo, floor_hi));
        else
          fl = 6'($urandom_range(0, 63));
        if ($urandom_range(0, 9) == 0)
          amt = 16'($urandom);
        else
          amt = 16'($urandom_range(0, weight_cap / 8 + 1));
        if (roll < 40)      send_word(ACT_PRESS, fl, 16'($urandom));
        else if (roll < 75) send_word(ACT_STEP, 6'($urandom), 16'($urandom));
        else if (roll < 83) send_word(ACT_ENTER, 6'($urandom), amt);
        else if (roll < 91) send_word(ACT_LEAVE, 6'($urandom), amt);
        else if (roll < 94) send_word(ACT_EMERGENCY, 6'($urandom), 16'($urandom));
        else if (roll < 98) send_word(ACT_CLEAR, 6'($urandom), 16'($urandom));
        else if (roll < 99) send_word(ACT_SPARE6, 6'($urandom), 16'($urandom));
        else                send_word(ACT_SPARE7, 6'($urandom), 16'($urandom));
      end
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= 10)
        $display("tb_top: word %0d %s expected %0h got %0h", results_seen, name, want, got);
    end
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    result_t got;
    if (!rst && rsp.valid && rsp.ready) begin
      got = rsp.result;
      if (due_status.size() == 0) begin
        errors++;
        if (errors <= 10) $display("tb_top: response word %0h with nothing expected", got);
      end else begin
        want = due_status.pop_front();
        check_field("ok", want.ok, got.ok);
        check_field("car_floor", want.car_floor, got.car_floor);
        check_field("direction_out", want.direction_out, got.direction_out);
        check_field("door_is_open", want.door_is_open, got.door_is_open);
        check_field("emergency_out", want.emergency_out, got.emergency_out);
        check_field("load_out", want.load_out, got.load_out);
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("tb_top: timed out with %0d words outstanding", due_status.size());
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin : rsp_stalls
    int hold;
    hold = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        if (hold == 0) rsp.ready <= 1'b1;
      end else if (!rst && !calm && $urandom_range(0, 99) < stall_odds) begin
        rsp.ready <= 1'b0;
        hold = $urandom_range(1, 9);
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  initial begin
    errors = 0;
    words_sent = 0;
    results_seen = 0;
    presses_taken = 0;
    steps_served = 0;
    regs_written = 0;
    cycles = 0;
    gap_odds = 15;
    stall_odds = 12;
    calm = 1'b0;
    floor_lo = 6'd0;
    floor_hi = 6'd63;
    locked_floors = 64'd0;
    weight_cap = 16'hFFFF;
    up_calls = 64'd0;
    down_calls = 64'd0;
    car_pos = 6'd0;
    car_dir = DIR_IDLE;
    car_door = 1'b0;
    alarm_on = 1'b0;
    car_load = 16'd0;
    req.valid <= 1'b0;
    req.item  <= '0;
    cfg.valid <= 1'b0;
    cfg.word  <= '0;
    rst       <= 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_press_rules();
    test_load_and_alarm();
    test_range_edges();
    test_random_traffic(1700);

    settle();
    repeat (8) @(posedge clk);
    $display("tb_top: %0d words sent, %0d checked under %0d register settings", words_sent,
             results_seen, regs_written);
    $display("tb_top: %0d presses taken, %0d steps served, %0d mismatches", presses_taken,
             steps_served, errors);
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
